// ===== src/gpp_pkg.sv =====
// Shared types and constants for the gyro packet parser.
`default_nettype none

package gpp_pkg;

    // Framing
    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [3:0] POS_HEADER  = 4'd0;
    localparam logic [3:0] POS_SUM_LO  = 4'd2;
    localparam logic [3:0] POS_RATE_L  = 4'd3;
    localparam logic [3:0] POS_RATE_H  = 4'd4;
    localparam logic [3:0] POS_ANGLE_L = 4'd5;
    localparam logic [3:0] POS_ANGLE_H = 4'd6;
    localparam logic [3:0] POS_AX_L    = 4'd7;
    localparam logic [3:0] POS_AX_H    = 4'd8;
    localparam logic [3:0] POS_AY_L    = 4'd9;
    localparam logic [3:0] POS_AY_H    = 4'd10;
    localparam logic [3:0] POS_AZ_L    = 4'd11;
    localparam logic [3:0] POS_AZ_H    = 4'd12;
    localparam logic [3:0] POS_SUM_HI  = 4'd13;
    localparam logic [3:0] POS_LAST    = 4'd14;

    // Divide by 100 as multiply by ceil(2^23 / 100) and shift right by 23
    localparam logic [16:0] DIV100_RECIP = 17'd83887;
    localparam int          DIV100_SHIFT = 23;

    // Whole-degree wrap
    localparam logic [9:0] WHOLE_LIMIT = 10'd180;
    localparam logic [9:0] WHOLE_WRAP  = 10'd655;

    // Packet content handed from the framer to the result stage
    typedef struct packed {
        logic        done;
        logic [15:0] rate;
        logic [15:0] angle;
        logic [9:0]  rate_q;
        logic [9:0]  angle_q;
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic        bad;
    } t_pkt;

    // Map quotients above the limit to the negative range, modulo 1024
    function automatic logic [9:0] fold_whole(input logic [9:0] q);
        logic [9:0] res;
        res = (q > WHOLE_LIMIT) ? (q - WHOLE_WRAP) : q;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/gpp_framer.sv =====
// Byte framer: position counter, field capture, running checksum, degree quotients.
`default_nettype none

module gpp_framer (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_beat,
    input  wire  [7:0]       i_byte,
    output logic             o_at_last,
    output gpp_pkg::t_pkt    o_pkt
);

    logic [3:0]  r_pos;
    logic [3:0]  n_pos;
    logic [7:0]  r_sum;
    logic [15:0] r_rate;
    logic [15:0] r_angle;
    logic [15:0] r_ax;
    logic [15:0] r_ay;
    logic [15:0] r_az;
    logic [9:0]  r_rate_q;
    logic [9:0]  r_angle_q;
    logic [32:0] w_rate_prod;
    logic [32:0] w_angle_prod;

    // Advance position; drop a non-header byte at the start of a packet
    always_comb begin
        n_pos = r_pos;
        if (i_beat) begin
            if (r_pos == gpp_pkg::POS_HEADER) begin
                n_pos = (i_byte == gpp_pkg::HEADER_BYTE) ? 4'd1 : gpp_pkg::POS_HEADER;
            end else if (r_pos == gpp_pkg::POS_LAST) begin
                n_pos = gpp_pkg::POS_HEADER;
            end else begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= gpp_pkg::POS_HEADER;
            r_sum <= 8'd0;
        end else begin
            r_pos <= n_pos;
            if (i_beat) begin
                if (r_pos == gpp_pkg::POS_HEADER) begin
                    r_sum <= 8'd0;
                end else if (r_pos >= gpp_pkg::POS_SUM_LO && r_pos <= gpp_pkg::POS_SUM_HI) begin
                    r_sum <= r_sum + i_byte;
                end
            end
        end
    end

    // Capture the little-endian words as their bytes arrive
    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            case (r_pos)
                gpp_pkg::POS_RATE_L:  r_rate[7:0]   <= i_byte;
                gpp_pkg::POS_RATE_H:  r_rate[15:8]  <= i_byte;
                gpp_pkg::POS_ANGLE_L: r_angle[7:0]  <= i_byte;
                gpp_pkg::POS_ANGLE_H: r_angle[15:8] <= i_byte;
                gpp_pkg::POS_AX_L:    r_ax[7:0]     <= i_byte;
                gpp_pkg::POS_AX_H:    r_ax[15:8]    <= i_byte;
                gpp_pkg::POS_AY_L:    r_ay[7:0]     <= i_byte;
                gpp_pkg::POS_AY_H:    r_ay[15:8]    <= i_byte;
                gpp_pkg::POS_AZ_L:    r_az[7:0]     <= i_byte;
                gpp_pkg::POS_AZ_H:    r_az[15:8]    <= i_byte;
                default: ;
            endcase
        end
    end

    // Divide rate and angle by 100; words settle many beats before the last byte
    assign w_rate_prod  = {17'd0, r_rate}  * {16'd0, gpp_pkg::DIV100_RECIP};
    assign w_angle_prod = {17'd0, r_angle} * {16'd0, gpp_pkg::DIV100_RECIP};

    always_ff @(posedge i_clk) begin
        r_rate_q  <= w_rate_prod[gpp_pkg::DIV100_SHIFT +: 10];
        r_angle_q <= w_angle_prod[gpp_pkg::DIV100_SHIFT +: 10];
    end

    // Hand the finished packet over on the last byte
    assign o_at_last     = (r_pos == gpp_pkg::POS_LAST);
    assign o_pkt.done    = i_beat && o_at_last;
    assign o_pkt.rate    = r_rate;
    assign o_pkt.angle   = r_angle;
    assign o_pkt.rate_q  = r_rate_q;
    assign o_pkt.angle_q = r_angle_q;
    assign o_pkt.accel_x = r_ax;
    assign o_pkt.accel_y = r_ay;
    assign o_pkt.accel_z = r_az;
    assign o_pkt.bad     = (r_sum != i_byte);

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= gpp_pkg::POS_LAST)
        else $error("framer position out of range");

    a_drop_nonheader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && r_pos == gpp_pkg::POS_HEADER && i_byte != gpp_pkg::HEADER_BYTE)
        |=> (r_pos == gpp_pkg::POS_HEADER))
        else $error("non-header byte started a packet");

endmodule

`default_nettype wire

// ===== src/gpp_result.sv =====
// Result register: folds whole degrees and holds one packet until taken.
`default_nettype none

module gpp_result (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gpp_pkg::t_pkt        i_pkt,
    input  wire                  i_stall,
    output logic                 o_valid,
    output logic signed [15:0]   o_rate_centideg,
    output logic signed [15:0]   o_angle_centideg,
    output logic signed [9:0]    o_rate_whole_deg,
    output logic signed [9:0]    o_angle_whole_deg,
    output logic [15:0]          o_accel_x,
    output logic [15:0]          o_accel_y,
    output logic [15:0]          o_accel_z,
    output logic                 o_checksum_bad
);

    logic        r_valid;
    logic [15:0] r_rate;
    logic [15:0] r_angle;
    logic [9:0]  r_rate_w;
    logic [9:0]  r_angle_w;
    logic [15:0] r_ax;
    logic [15:0] r_ay;
    logic [15:0] r_az;
    logic        r_bad;

    // Set on a finished packet, clear when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pkt.done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_pkt.done) begin
            r_rate    <= i_pkt.rate;
            r_angle   <= i_pkt.angle;
            r_rate_w  <= gpp_pkg::fold_whole(i_pkt.rate_q);
            r_angle_w <= gpp_pkg::fold_whole(i_pkt.angle_q);
            r_ax      <= i_pkt.accel_x;
            r_ay      <= i_pkt.accel_y;
            r_az      <= i_pkt.accel_z;
            r_bad     <= i_pkt.bad;
        end
    end

    assign o_valid           = r_valid;
    assign o_rate_centideg   = $signed(r_rate);
    assign o_angle_centideg  = $signed(r_angle);
    assign o_rate_whole_deg  = $signed(r_rate_w);
    assign o_angle_whole_deg = $signed(r_angle_w);
    assign o_accel_x         = r_ax;
    assign o_accel_y         = r_ay;
    assign o_accel_z         = r_az;
    assign o_checksum_bad    = r_bad;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pkt.done |-> !(r_valid && i_stall))
        else $error("packet loaded over a result still waiting");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !$past(r_valid)) |-> $past(i_pkt.done))
        else $error("result valid without a finished packet");

    a_whole_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($signed(r_rate_w) >= -10'sd474 && $signed(r_rate_w) <= 10'sd180))
        else $error("whole-degree rate out of range");

endmodule

`default_nettype wire

// ===== src/gyro_packet_parser.sv =====
// Top level of the gyro packet parser.
//
//   Channel  | Direction | Handshake                    | Payload
//   rx       | in        | i_rx_valid / o_rx_stall      | i_rx_byte
//   res      | out       | o_res_valid / i_res_stall    | o_rate_centideg .. o_checksum_bad
//
// One byte beat per cycle is taken, save when the 15th byte is stalled; a packet's result
// appears in the cycle after its 15th byte, from the result register. Rate and angle are
// divided by 100 in a multiplier whose output is registered while the later bytes stream in.
// Synchronous active-low reset clears the position, checksum and result valid.
// Only the 15th byte is stalled, and only while a previous result waits.
`default_nettype none

module gyro_packet_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_rx_valid,
    output logic                o_rx_stall,
    input  wire  [7:0]          i_rx_byte,
    output logic                o_res_valid,
    input  wire                 i_res_stall,
    output logic signed [15:0]  o_rate_centideg,
    output logic signed [15:0]  o_angle_centideg,
    output logic signed [9:0]   o_rate_whole_deg,
    output logic signed [9:0]   o_angle_whole_deg,
    output logic [15:0]         o_accel_x,
    output logic [15:0]         o_accel_y,
    output logic [15:0]         o_accel_z,
    output logic                o_checksum_bad
);

    logic          w_beat;
    logic          w_at_last;
    gpp_pkg::t_pkt w_pkt;

    // Hold the last byte only while the result register is occupied
    assign o_rx_stall = w_at_last && o_res_valid && i_res_stall;
    assign w_beat     = i_rx_valid && !o_rx_stall;

    gpp_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (w_beat),
        .i_byte    (i_rx_byte),
        .o_at_last (w_at_last),
        .o_pkt     (w_pkt)
    );

    gpp_result u_result (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pkt             (w_pkt),
        .i_stall           (i_res_stall),
        .o_valid           (o_res_valid),
        .o_rate_centideg   (o_rate_centideg),
        .o_angle_centideg  (o_angle_centideg),
        .o_rate_whole_deg  (o_rate_whole_deg),
        .o_angle_whole_deg (o_angle_whole_deg),
        .o_accel_x         (o_accel_x),
        .o_accel_y         (o_accel_y),
        .o_accel_z         (o_accel_z),
        .o_checksum_bad    (o_checksum_bad)
    );

endmodule

`default_nettype wire

// ===== tb/tb_gyro_packet_parser.sv =====
// Testbench for the gyro packet parser: framed byte stream in, checked packet results out.
`timescale 1ns / 1ps

module tb_gyro_packet_parser;

    localparam int DEG_DIVISOR = 100;
    localparam int PACKET_LEN  = int'(gpp_pkg::POS_LAST) + 1;
    localparam int PHASE_BYTES = 320;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 5000;

    // One decoded packet as seen on the result port
    typedef struct {
        logic signed [15:0] rate_centideg;
        logic signed [15:0] angle_centideg;
        logic signed [9:0]  rate_whole_deg;
        logic signed [9:0]  angle_whole_deg;
        logic [15:0]        accel_x;
        logic [15:0]        accel_y;
        logic [15:0]        accel_z;
        logic               checksum_bad;
    } t_gyro_sample;

    // Track framing on accepted bytes and match decoded packets in order
    class t_gyro_scoreboard;
        t_gyro_sample expected_packets[$];
        logic [3:0]   byte_pos;
        logic [7:0]   pkt_bytes[PACKET_LEN];
        logic [7:0]   sum_acc;
        int           errors;

        function new();
            byte_pos = gpp_pkg::POS_HEADER;
            sum_acc  = 8'd0;
            errors   = 0;
            foreach (pkt_bytes[i]) pkt_bytes[i] = 8'd0;
        endfunction

        function logic signed [9:0] whole_degrees(input logic [15:0] raw);
            int q;
            q = int'(raw) / DEG_DIVISOR;
            if (q > int'(gpp_pkg::WHOLE_LIMIT))
                q = q - int'(gpp_pkg::WHOLE_WRAP);
            return q[9:0];
        endfunction

        // Advance the framer by one accepted byte beat; queue a packet on the last byte
        function void frame_byte(input logic [7:0] b);
            t_gyro_sample pkt;
            logic [15:0]  rate_raw;
            logic [15:0]  angle_raw;
            if (byte_pos == gpp_pkg::POS_HEADER) begin
                // drop anything but a header at the start of a packet
                if (b != gpp_pkg::HEADER_BYTE)
                    return;
                sum_acc = 8'd0;
            end
            pkt_bytes[byte_pos] = b;
            if (byte_pos >= gpp_pkg::POS_SUM_LO && byte_pos <= gpp_pkg::POS_SUM_HI)
                sum_acc = sum_acc + b;
            if (byte_pos != gpp_pkg::POS_LAST) begin
                byte_pos = byte_pos + 4'd1;
                return;
            end
            byte_pos  = gpp_pkg::POS_HEADER;
            rate_raw  = {pkt_bytes[gpp_pkg::POS_RATE_H], pkt_bytes[gpp_pkg::POS_RATE_L]};
            angle_raw = {pkt_bytes[gpp_pkg::POS_ANGLE_H], pkt_bytes[gpp_pkg::POS_ANGLE_L]};
            pkt.rate_centideg   = rate_raw;
            pkt.angle_centideg  = angle_raw;
            pkt.rate_whole_deg  = whole_degrees(rate_raw);
            pkt.angle_whole_deg = whole_degrees(angle_raw);
            pkt.accel_x = {pkt_bytes[gpp_pkg::POS_AX_H], pkt_bytes[gpp_pkg::POS_AX_L]};
            pkt.accel_y = {pkt_bytes[gpp_pkg::POS_AY_H], pkt_bytes[gpp_pkg::POS_AY_L]};
            pkt.accel_z = {pkt_bytes[gpp_pkg::POS_AZ_H], pkt_bytes[gpp_pkg::POS_AZ_L]};
            pkt.checksum_bad = (sum_acc != pkt_bytes[gpp_pkg::POS_LAST]);
            expected_packets.push_back(pkt);
        endfunction

        function void check_field(input string name, input int exp, input int act);
            if (exp != act) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
                errors++;
            end
        endfunction

        // Match one result beat against the oldest queued packet
        function void compare_packet(input t_gyro_sample got);
            t_gyro_sample exp;
            if (expected_packets.size() == 0) begin
                $display("%0t: result with no packet queued: rate %0d, angle %0d",
                         $time, got.rate_centideg, got.angle_centideg);
                errors++;
                return;
            end
            exp = expected_packets.pop_front();
            check_field("rate_centideg", exp.rate_centideg, got.rate_centideg);
            check_field("angle_centideg", exp.angle_centideg, got.angle_centideg);
            check_field("rate_whole_deg", exp.rate_whole_deg, got.rate_whole_deg);
            check_field("angle_whole_deg", exp.angle_whole_deg, got.angle_whole_deg);
            check_field("accel_x", exp.accel_x, got.accel_x);
            check_field("accel_y", exp.accel_y, got.accel_y);
            check_field("accel_z", exp.accel_z, got.accel_z);
            check_field("checksum_bad", exp.checksum_bad, got.checksum_bad);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_rx_valid;
    logic               o_rx_stall;
    logic [7:0]         i_rx_byte;
    logic               o_res_valid;
    logic               i_res_stall;
    logic signed [15:0] o_rate_centideg;
    logic signed [15:0] o_angle_centideg;
    logic signed [9:0]  o_rate_whole_deg;
    logic signed [9:0]  o_angle_whole_deg;
    logic [15:0]        o_accel_x;
    logic [15:0]        o_accel_y;
    logic [15:0]        o_accel_z;
    logic               o_checksum_bad;

    t_gyro_scoreboard sb = new();
    t_gyro_sample     seen_packet;
    int               bytes_sent    = 0;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    bit               hold_request  = 1'b0;

    gyro_packet_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_stall        (o_rx_stall),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_stall       (i_res_stall),
        .o_rate_centideg   (o_rate_centideg),
        .o_angle_centideg  (o_angle_centideg),
        .o_rate_whole_deg  (o_rate_whole_deg),
        .o_angle_whole_deg (o_angle_whole_deg),
        .o_accel_x         (o_accel_x),
        .o_accel_y         (o_accel_y),
        .o_accel_z         (o_accel_z),
        .o_checksum_bad    (o_checksum_bad)
    );

    always #6 i_clk = ~i_clk;

    // Drive the result stall: random stalls, or a long counted hold-off on request
    initial begin
        int hold_left;
        hold_left   = 0;
        i_res_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_res_stall <= 1'b1;
            end else begin
                i_res_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Capture each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            seen_packet.rate_centideg   = o_rate_centideg;
            seen_packet.angle_centideg  = o_angle_centideg;
            seen_packet.rate_whole_deg  = o_rate_whole_deg;
            seen_packet.angle_whole_deg = o_angle_whole_deg;
            seen_packet.accel_x         = o_accel_x;
            seen_packet.accel_y         = o_accel_y;
            seen_packet.accel_z         = o_accel_z;
            seen_packet.checksum_bad    = o_checksum_bad;
            sb.compare_packet(seen_packet);
        end
    end

    // Offer one byte beat, with random idle cycles first, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            i_rx_byte  <= 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        sb.frame_byte(b);
        bytes_sent++;
    endtask

    // Send a packet, or only its first len bytes for a broken one
    task automatic send_packet(input logic [15:0] rate, input logic [15:0] angle,
                               input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input bit sum_ok, input int len);
        logic [7:0] frame[PACKET_LEN];
        logic [7:0] sum;
        frame[gpp_pkg::POS_HEADER]  = gpp_pkg::HEADER_BYTE;
        frame[1]                    = 8'($urandom_range(0, 255));
        frame[gpp_pkg::POS_SUM_LO]  = 8'($urandom_range(0, 255));
        frame[gpp_pkg::POS_RATE_L]  = rate[7:0];
        frame[gpp_pkg::POS_RATE_H]  = rate[15:8];
        frame[gpp_pkg::POS_ANGLE_L] = angle[7:0];
        frame[gpp_pkg::POS_ANGLE_H] = angle[15:8];
        frame[gpp_pkg::POS_AX_L]    = ax[7:0];
        frame[gpp_pkg::POS_AX_H]    = ax[15:8];
        frame[gpp_pkg::POS_AY_L]    = ay[7:0];
        frame[gpp_pkg::POS_AY_H]    = ay[15:8];
        frame[gpp_pkg::POS_AZ_L]    = az[7:0];
        frame[gpp_pkg::POS_AZ_H]    = az[15:8];
        frame[gpp_pkg::POS_SUM_HI]  = 8'($urandom_range(0, 255));
        sum = 8'd0;
        for (int i = int'(gpp_pkg::POS_SUM_LO); i <= int'(gpp_pkg::POS_SUM_HI); i++)
            sum = sum + frame[i];
        frame[gpp_pkg::POS_LAST] = sum_ok ? sum : sum + 8'($urandom_range(1, 255));
        for (int i = 0; i < len; i++)
            send_byte(frame[i]);
    endtask

    // Favor the wrap and sign boundaries of the decoded words
    function automatic logic [15:0] pick_word();
        logic [15:0] corners[8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                                    16'd18099, 16'd18100, 16'd18199, 16'd65499};
        if ($urandom_range(0, 3) == 0)
            return corners[3'($urandom_range(0, 7))];
        return 16'($urandom_range(0, 65535));
    endfunction

    // Fill out a partial packet so the next one starts on a header
    task automatic realign();
        while (sb.byte_pos != gpp_pkg::POS_HEADER)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int waited;
        int target;
        int pick;
        i_rst_n    = 1'b0;
        i_rx_valid = 1'b0;
        i_rx_byte  = 8'd0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: stray bytes before a header, sign and wrap extremes, both checksums
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_packet(16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h00FF, 1'b0, PACKET_LEN);
        send_packet(16'd18100, 16'd18099, 16'h7FFF, 16'h8000, 16'hFF00, 1'b1, PACKET_LEN);

        // Random: mostly whole packets, some noise and truncated packets, per idling phase
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                3: begin send_idle_pct = 8;  stall_pct = 8;  end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_request  = 1'b1;
                end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                realign();
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    send_packet(pick_word(), pick_word(), pick_word(), pick_word(),
                                pick_word(), $urandom_range(0, 99) < 75, PACKET_LEN);
                end else if (pick < 90) begin
                    repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
                end else begin
                    send_packet(pick_word(), pick_word(), pick_word(), pick_word(),
                                pick_word(), 1'b1, $urandom_range(1, PACKET_LEN - 1));
                end
            end
        end

        // Release the input and drain every queued packet
        @(negedge i_clk);
        i_rx_valid    <= 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        waited         = 0;
        while (sb.expected_packets.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.expected_packets.size() != 0) begin
            $display("%0t: %0d packets never came out", $time, sb.expected_packets.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== gyro_packet_parser.f =====
src/gpp_pkg.sv
src/gpp_framer.sv
src/gpp_result.sv
src/gyro_packet_parser.sv
tb/tb_gyro_packet_parser.sv
